// ===== sv/fles_pkg.sv =====
// Package for the flash log entry seek block.
// Widths, register indexes, end reasons, scan phases and reset values.
// No dependencies.
package fles_pkg;

    localparam int MAX_SECTOR_BYTES = 131072;
    localparam int MAX_CHUNK_BYTES  = 4096;

    localparam int OFF_W      = $clog2(MAX_SECTOR_BYTES) + 1;
    localparam int CHUNK_W    = $clog2(MAX_CHUNK_BYTES) + 1;
    localparam int CNT_W      = 17;
    localparam int SKIP_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int REASON_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFF_W;
    localparam int LEN_W      = 15;
    localparam int LEN2_SHIFT = 7;

    localparam logic [BYTE_W-1:0] LEN2_FLAG    = 8'h80;
    localparam logic [BYTE_W-1:0] LEN1_MASK    = 8'h7F;
    localparam logic [1:0]        MARKER_BYTES = 2'd1;
    localparam logic [1:0]        PEEK_BYTES   = 2'd2;

    localparam logic [BYTE_W-1:0]  ERASE_RESET  = 8'hFF;
    localparam logic [OFF_W-1:0]   SECTOR_RESET = OFF_W'(4096);
    localparam logic [OFF_W-1:0]   START_RESET  = '0;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET  = CHUNK_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERASE_VALUE  = 2'd0,
        CFG_SECTOR_SIZE  = 2'd1,
        CFG_START_OFFSET = 2'd2,
        CFG_CHUNK_SIZE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [REASON_W-1:0] {
        END_TERMINATOR = 2'd0,
        END_SECTOR_END = 2'd1,
        END_TOO_FEW    = 2'd2,
        END_READ_FAIL  = 2'd3
    } end_reason_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_HEAD_FIRST  = 5'b00010,
        PH_HEAD_SECOND = 5'b00100,
        PH_SKIP        = 5'b01000,
        PH_HOP         = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  erase_value;
        logic [OFF_W-1:0]   sector_size;
        logic [OFF_W-1:0]   start_offset;
        logic [CHUNK_W-1:0] chunk_size;
    } cfg_t;

endpackage

// ===== sv/fles_req_if.sv =====
// Input channel of the flash log entry seek block: one sector byte per beat.
// Depends on fles_pkg.
interface fles_req_if import fles_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_seek;
    logic [BYTE_W-1:0] data_byte;
    logic              read_failed;

    modport source (output valid, start_seek, data_byte, read_failed, input ready);
    modport sink   (input valid, start_seek, data_byte, read_failed, output ready);
endinterface

// ===== sv/fles_rsp_if.sv =====
// Result channel of the flash log entry seek block: one beat per finished seek.
// Depends on fles_pkg.
interface fles_rsp_if import fles_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFF_W-1:0]    final_offset;
    logic [CNT_W-1:0]    entry_count;
    logic [CNT_W-1:0]    read_count;
    logic [REASON_W-1:0] end_reason;

    modport source (output valid, final_offset, entry_count, read_count, end_reason,
                    input ready);
    modport sink   (input valid, final_offset, entry_count, read_count, end_reason,
                    output ready);
endinterface

// ===== sv/flash_log_entry_seek_top.sv =====
// Top level of the flash log entry seek block: input stage, scan state, result register.
// Depends on fles_pkg, fles_req_if, fles_rsp_if and fles_cfg.
//
// Stream the sector bytes from start_offset on, one per beat, the first with start_seek
// set; each byte passes through a single decode stage between the input register
// and the scan state, so a byte is accepted every cycle while the result side is free.
// The block splits the stream into read chunks, decodes each length header (XOR with the
// inverted erase value, one or two bytes), skips payload and marker, and returns one
// result beat when the seek ends: at an erased terminator, at the sector end, with fewer
// than two bytes left or a chunk size under two, or on a failed chunk read. A result
// waits in its own register; bytes that do not end a seek keep flowing behind it.
// Write configuration while no seek is running.
module flash_log_entry_seek_top import fles_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fles_req_if.sink              req,
    fles_rsp_if.source            rsp
);

    cfg_t cfg;

    fles_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    function automatic logic [OFF_W-1:0] chunk_end(input logic [OFF_W-1:0]   cb,
                                                    input logic [OFF_W-1:0]   ss,
                                                    input logic [CHUNK_W-1:0] cs);
        logic [OFF_W-1:0] rem;
        logic [OFF_W-1:0] len;
        begin
            rem = ss - cb;
            len = (OFF_W'(cs) < rem) ? OFF_W'(cs) : rem;
            chunk_end = (cb >= ss) ? cb : cb + len;
        end
    endfunction

    logic               s1_valid_reg;
    logic               s1_start_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               s1_rf_reg;

    phase_t             phase_reg, phase_next;
    logic [OFF_W-1:0]   pos_reg, pos_next;
    logic [OFF_W-1:0]   cb_reg, cb_next;
    logic [OFF_W-1:0]   eb_reg, eb_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]   ent_reg, ent_next;
    logic [CNT_W-1:0]   rd_reg, rd_next;
    logic               pend_reg, pend_next;

    logic               ov_reg;
    logic [OFF_W-1:0]   out_off_reg;
    logic [CNT_W-1:0]   out_ent_reg;
    logic [CNT_W-1:0]   out_rd_reg;
    end_reason_t        out_reason_reg;

    logic               fin;
    logic [OFF_W:0]     fin_off;
    end_reason_t        fin_reason;
    logic               s1_adv;
    logic               req_accept;

    logic               start_past;
    phase_t             ph;
    logic               pend;
    logic [CNT_W-1:0]   ent;
    logic [CNT_W-1:0]   rd;
    logic [OFF_W-1:0]   p;
    logic [OFF_W:0]     p1;
    logic [OFF_W:0]     ss_x;
    logic [OFF_W-1:0]   cb_end;
    logic [OFF_W:0]     cb_end_x;
    logic               open_now;
    logic               short_chunk;
    logic [BYTE_W-1:0]  not_ev;
    logic [BYTE_W-1:0]  b0;
    logic [BYTE_W-1:0]  b1;
    logic               two_byte;
    logic [LEN_W-1:0]   len;
    logic [SKIP_W-1:0]  total;
    logic [OFF_W:0]     target;
    logic [OFF_W-1:0]   rem;
    logic [SKIP_W-1:0]  skip_dec;

    always_comb
    begin
        start_past = s1_start_reg && (cfg.start_offset >= cfg.sector_size);
        ph   = s1_start_reg ? PH_HEAD_FIRST : phase_reg;
        pend = s1_start_reg ? 1'b1 : pend_reg;
        ent  = s1_start_reg ? '0 : ent_reg;
        rd   = s1_start_reg ? '0 : rd_reg;
        p    = s1_start_reg ? cfg.start_offset : pos_reg;
        p1   = {1'b0, p} + 1'b1;
        ss_x = {1'b0, cfg.sector_size};

        cb_end   = chunk_end(cb_reg, cfg.sector_size, cfg.chunk_size);
        cb_end_x = {1'b0, cb_end};
        open_now = pend || (p1 >= cb_end_x);
        short_chunk = (({1'b0, p} + 2'd2) > ss_x) || (cfg.chunk_size < CHUNK_W'(PEEK_BYTES));

        not_ev   = ~cfg.erase_value;
        b0       = held_reg ^ not_ev;
        b1       = s1_byte_reg ^ not_ev;
        two_byte = (b0 & LEN2_FLAG) != '0;
        len      = two_byte ? ((LEN_W'(b1) << LEN2_SHIFT) | LEN_W'(b0 & LEN1_MASK))
                            : LEN_W'(b0);
        total    = SKIP_W'(len) + SKIP_W'(two_byte ? PEEK_BYTES : 2'd1) + SKIP_W'(MARKER_BYTES);
        target   = {1'b0, eb_reg} + (OFF_W+1)'(total);
        rem      = (cb_end > eb_reg) ? (cb_end - eb_reg) : '0;
        skip_dec = skip_reg - SKIP_W'(skip_reg != '0);

        phase_next = ph;
        pos_next   = (ph == PH_IDLE) ? p : p1[OFF_W-1:0];
        cb_next    = cb_reg;
        eb_next    = eb_reg;
        skip_next  = skip_reg;
        held_next  = held_reg;
        ent_next   = ent;
        rd_next    = rd;
        pend_next  = pend;
        fin        = 1'b0;
        fin_off    = {1'b0, p};
        fin_reason = END_SECTOR_END;

        if (start_past)
        begin
            pos_next = p;
            fin      = 1'b1;
        end
        else
        begin
            case (ph)
                PH_HEAD_FIRST:
                begin
                    if (open_now)
                    begin
                        cb_next   = p;
                        rd_next   = rd + 1'b1;
                        pend_next = 1'b0;
                        if (s1_rf_reg)
                        begin
                            fin        = 1'b1;
                            fin_reason = END_READ_FAIL;
                        end
                        else if (short_chunk)
                        begin
                            fin        = 1'b1;
                            fin_reason = END_TOO_FEW;
                        end
                    end
                    eb_next    = p;
                    held_next  = s1_byte_reg;
                    phase_next = PH_HEAD_SECOND;
                end
                PH_HEAD_SECOND:
                begin
                    if (held_reg == cfg.erase_value && s1_byte_reg == cfg.erase_value)
                    begin
                        fin        = 1'b1;
                        fin_off    = {1'b0, eb_reg};
                        fin_reason = END_TERMINATOR;
                    end
                    else if (OFF_W'(total) > rem)
                    begin
                        if (target >= ss_x)
                        begin
                            fin     = 1'b1;
                            fin_off = ss_x;
                        end
                        else if (target <= p1)
                        begin
                            phase_next = PH_HEAD_FIRST;
                            pend_next  = 1'b1;
                        end
                        else
                        begin
                            skip_next  = SKIP_W'(target - p1);
                            phase_next = PH_HOP;
                        end
                    end
                    else
                    begin
                        ent_next = ent + 1'b1;
                        if (target <= p1)
                        begin
                            phase_next = PH_HEAD_FIRST;
                            if (p1 >= cb_end_x)
                            begin
                                if (p1 >= ss_x)
                                begin
                                    fin     = 1'b1;
                                    fin_off = p1;
                                end
                                else
                                begin
                                    pend_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            skip_next  = SKIP_W'(target - p1);
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_HEAD_FIRST;
                        if (p1 >= cb_end_x)
                        begin
                            if (p1 >= ss_x)
                            begin
                                fin     = 1'b1;
                                fin_off = p1;
                            end
                            else
                            begin
                                pend_next = 1'b1;
                            end
                        end
                    end
                end
                PH_HOP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_HEAD_FIRST;
                        pend_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end

        if (fin)
        begin
            phase_next = PH_IDLE;
            pend_next  = 1'b0;
        end
    end

    assign s1_adv     = s1_valid_reg && (!fin || !ov_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_adv;
    assign req_accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_start_reg <= req.start_seek;
            s1_byte_reg  <= req.data_byte;
            s1_rf_reg    <= req.read_failed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cb_reg    <= '0;
            eb_reg    <= '0;
            skip_reg  <= '0;
            held_reg  <= '0;
            ent_reg   <= '0;
            rd_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cb_reg    <= cb_next;
            eb_reg    <= eb_next;
            skip_reg  <= skip_next;
            held_reg  <= held_next;
            ent_reg   <= ent_next;
            rd_reg    <= rd_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (s1_adv && fin)
        begin
            ov_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && fin)
        begin
            out_off_reg    <= fin_off[OFF_W-1:0];
            out_ent_reg    <= ent_next;
            out_rd_reg     <= rd_next;
            out_reason_reg <= fin_reason;
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.final_offset = out_off_reg;
    assign rsp.entry_count  = out_ent_reg;
    assign rsp.read_count   = out_rd_reg;
    assign rsp.end_reason   = out_reason_reg;

`ifndef SYNTH
    a_fin_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && fin |=> phase_reg == PH_IDLE)
        else $error("seek end did not return the scan to idle");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP || phase_reg == PH_HOP) |-> skip_reg != '0)
        else $error("skip phase with an empty skip count");

    a_pend_in_head: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> phase_reg == PH_HEAD_FIRST)
        else $error("chunk open pending outside the first header byte");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !rsp.ready |=> ov_reg)
        else $error("result beat dropped while stalled");
`endif

endmodule

// ===== sv/fles_cfg.sv =====
// Configuration register file of the flash log entry seek block.
// Depends on fles_pkg.
module fles_cfg import fles_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.erase_value  <= ERASE_RESET;
            cfg_reg.sector_size  <= SECTOR_RESET;
            cfg_reg.start_offset <= START_RESET;
            cfg_reg.chunk_size   <= CHUNK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ERASE_VALUE:  cfg_reg.erase_value  <= cfg_data[BYTE_W-1:0];
                CFG_SECTOR_SIZE:  cfg_reg.sector_size  <= cfg_data[OFF_W-1:0];
                CFG_START_OFFSET: cfg_reg.start_offset <= cfg_data[OFF_W-1:0];
                CFG_CHUNK_SIZE:   cfg_reg.chunk_size   <= cfg_data[CHUNK_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
